FILE: rtl/assert_macros.svh
// Assertion macros shared by the quintic Hermite evaluator RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too
`define QHE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the ante sequence matches, cons holds in the following cycle
`define QHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qhe_pkg.sv
// Package for the quintic Hermite evaluator: widths, pipeline payload type,
// coefficient weight table and the shared fixed-point helper functions.
// No dependencies.
package qhe_pkg;

  localparam int IN_W   = 32;             // field width, signed Q16.16
  localparam int U_W    = 17;             // u width, unsigned Q1.16
  localparam int U_FRAC = 16;
  localparam int NIN    = 6;              // boundary values per item
  localparam int NLANE  = 3;              // q, q', q''
  localparam int NSTEP  = 5;              // Horner steps
  // Doubled coefficients reach about 2^43 in magnitude on the q'' lane
  localparam int ACC_W  = 45;
  localparam int PROD_W = ACC_W + U_W + 1;

  localparam logic [U_W-1:0] U_ONE = U_W'(1) << U_FRAC;

  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;

  typedef logic signed [IN_W-1:0]   in_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [ACC_W:0]    accx_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Payload traveling down the pipeline
  typedef struct packed {
    logic [U_W-1:0]                u;
    acc_t [NLANE-1:0]              acc;
    acc_t [NLANE-1:0][NSTEP:0]     term;
  } pipe_t;

  // Weights of (p0, v0, a0, p1, v1, a1) for each lane's Horner terms.
  // Term 0 seeds the accumulator; later lanes lead with zeros so all
  // three lanes run the same five steps.
  localparam int COEF_K [NLANE][NSTEP+1][NIN] = '{
    // position: d5, d4, d3, d2, d1, d0
    '{ '{ -12,  -6,  -1,  12,  -6,   1},
       '{  30,  16,   3, -30,  14,  -2},
       '{ -20, -12,  -3,  20,  -8,   1},
       '{   0,   0,   1,   0,   0,   0},
       '{   0,   2,   0,   0,   0,   0},
       '{   2,   0,   0,   0,   0,   0} },
    // first derivative: 0, 5d5, 4d4, 3d3, 2d2, d1
    '{ '{   0,   0,   0,   0,   0,   0},
       '{ -60, -30,  -5,  60, -30,   5},
       '{ 120,  64,  12,-120,  56,  -8},
       '{ -60, -36,  -9,  60, -24,   3},
       '{   0,   0,   2,   0,   0,   0},
       '{   0,   2,   0,   0,   0,   0} },
    // second derivative: 0, 0, 20d5, 12d4, 6d3, 2d2
    '{ '{   0,   0,   0,   0,   0,   0},
       '{   0,   0,   0,   0,   0,   0},
       '{-240,-120, -20, 240,-120,  20},
       '{ 360, 192,  36,-360, 168, -24},
       '{-120, -72, -18, 120, -48,   6},
       '{   0,   0,   2,   0,   0,   0} }
  };

  // Weighted sum of the six boundary values; constant weights map to shift-adds
  function automatic acc_t lin(input in_t [NIN-1:0] x, input int lane, input int k);
    acc_t s;
    s = '0;
    for (int i = 0; i < NIN; i++) begin
      s = s + acc_t'(COEF_K[lane][k][i]) * acc_t'(x[i]);
    end
    return s;
  endfunction

  // round(a * u / 2^16), half toward plus infinity
  function automatic acc_t mul_u(input acc_t a, input logic [U_W-1:0] u);
    prod_t p;
    p = prod_t'(a) * prod_t'({1'b0, u});
    p = p + (prod_t'(1) <<< (U_FRAC - 1));
    return acc_t'(p >>> U_FRAC);
  endfunction

  // Halve a doubled value, rounding half up, then saturate to 32 bits
  function automatic in_t finish(input acc_t d);
    accx_t s;
    accx_t r;
    s = accx_t'(d) + accx_t'(1);
    r = s >>> 1;
    if (r > accx_t'(OUT_MAX)) begin
      r = accx_t'(OUT_MAX);
    end else if (r < accx_t'(OUT_MIN)) begin
      r = accx_t'(OUT_MIN);
    end
    return in_t'(r);
  endfunction

endpackage

FILE: rtl/qhe_coef.sv
// First pipeline stage: clamps u and forms the doubled monomial
// coefficients of all three Horner lanes. Depends on qhe_pkg.
module qhe_coef (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  qhe_pkg::in_t               start_pos_i,
  input  qhe_pkg::in_t               start_vel_i,
  input  qhe_pkg::in_t               start_acc_i,
  input  qhe_pkg::in_t               end_pos_i,
  input  qhe_pkg::in_t               end_vel_i,
  input  qhe_pkg::in_t               end_acc_i,
  input  logic [qhe_pkg::U_W-1:0]    param_u_i,
  output logic                       valid_o,
  output qhe_pkg::pipe_t             pipe_o
);

  logic                              valid_q;
  qhe_pkg::pipe_t                    pipe_d;
  qhe_pkg::pipe_t                    pipe_q;
  qhe_pkg::in_t [qhe_pkg::NIN-1:0]   bnd;

  assign bnd = {end_acc_i, end_vel_i, end_pos_i, start_acc_i, start_vel_i, start_pos_i};

  // u above one is treated as one; lane terms from the weight table
  always_comb begin
    pipe_d   = '0;
    pipe_d.u = (param_u_i > qhe_pkg::U_ONE) ? qhe_pkg::U_ONE : param_u_i;
    for (int l = 0; l < qhe_pkg::NLANE; l++) begin
      for (int k = 0; k <= qhe_pkg::NSTEP; k++) begin
        pipe_d.term[l][k] = qhe_pkg::lin(bnd, l, k);
      end
      pipe_d.acc[l] = pipe_d.term[l][0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: rtl/qhe_step.sv
// One Horner step for all three lanes: acc = round(acc * u) + term[STEP].
// Depends on qhe_pkg.
module qhe_step #(
  parameter int STEP = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qhe_pkg::pipe_t  pipe_i,
  output logic            valid_o,
  output qhe_pkg::pipe_t  pipe_o
);

  logic           valid_q;
  qhe_pkg::pipe_t pipe_d;
  qhe_pkg::pipe_t pipe_q;

  // One multiply-round-add per lane
  always_comb begin
    pipe_d = pipe_i;
    for (int l = 0; l < qhe_pkg::NLANE; l++) begin
      pipe_d.acc[l] = qhe_pkg::mul_u(pipe_i.acc[l], pipe_i.u) + pipe_i.term[l][STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

FILE: rtl/qhe_finish.sv
// Output stage: halves the doubled Horner sums with rounding, saturates
// them to 32 bits and holds the result register. Depends on qhe_pkg.
module qhe_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qhe_pkg::pipe_t  pipe_i,
  output logic            valid_o,
  output qhe_pkg::in_t    position_o,
  output qhe_pkg::in_t    first_deriv_o,
  output qhe_pkg::in_t    second_deriv_o
);

  logic         valid_q;
  qhe_pkg::in_t pos_q;
  qhe_pkg::in_t fst_q;
  qhe_pkg::in_t snd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Round and clip each lane
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      pos_q <= qhe_pkg::finish(pipe_i.acc[0]);
      fst_q <= qhe_pkg::finish(pipe_i.acc[1]);
      snd_q <= qhe_pkg::finish(pipe_i.acc[2]);
    end
  end

  assign valid_o        = valid_q;
  assign position_o     = pos_q;
  assign first_deriv_o  = fst_q;
  assign second_deriv_o = snd_q;

endmodule

FILE: rtl/quintic_hermite_evaluator.sv
// Quintic Hermite evaluator, one axis of one segment per item.
// Input channel: in_valid_i / in_ready_o with the six boundary values
// (signed Q16.16) and param_u_i (unsigned Q1.16, values above 1.0 clamp).
// Output channel: out_valid_o / out_ready_i with position, first and
// second derivative, signed Q16.16, saturated to 32 bits.
// Pipeline: seven register stages (coefficient stage, five Horner stages,
// rounding/saturation stage).
// Throughput: one item per cycle while the output is not stalled; each Horner
// stage holds one 45x17 multiply per lane, so all stages accept back to back.
// Stalls: each stage advances when it is empty or the one after it
// advances, so bubbles are squeezed out and the block keeps taking items
// while a finished result waits, until all seven stages are full.
// Reset: clears every stage valid bit; no item is in flight afterwards.
// The x and y axes are sent as separate items; the block keeps no state.
// Depends on qhe_pkg, qhe_coef, qhe_step, qhe_finish, assert_macros.svh.
`include "assert_macros.svh"

module quintic_hermite_evaluator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  qhe_pkg::in_t             start_pos_i,
  input  qhe_pkg::in_t             start_vel_i,
  input  qhe_pkg::in_t             start_acc_i,
  input  qhe_pkg::in_t             end_pos_i,
  input  qhe_pkg::in_t             end_vel_i,
  input  qhe_pkg::in_t             end_acc_i,
  input  logic [qhe_pkg::U_W-1:0]  param_u_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output qhe_pkg::in_t             position_o,
  output qhe_pkg::in_t             first_deriv_o,
  output qhe_pkg::in_t             second_deriv_o
);

  localparam int NST = qhe_pkg::NSTEP + 2;  // coef, Horner steps, finish

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic           in_xfer;
  qhe_pkg::pipe_t pipe [qhe_pkg::NSTEP+1];

  // Stage advance chain: a stage moves when empty or its successor moves
  assign en[NST-1] = !vld[NST-1] || out_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign in_ready_o = en[0];
  assign in_xfer    = in_valid_i && in_ready_o;

  qhe_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en[0]),
    .valid_i     (in_valid_i),
    .start_pos_i (start_pos_i),
    .start_vel_i (start_vel_i),
    .start_acc_i (start_acc_i),
    .end_pos_i   (end_pos_i),
    .end_vel_i   (end_vel_i),
    .end_acc_i   (end_acc_i),
    .param_u_i   (param_u_i),
    .valid_o     (vld[0]),
    .pipe_o      (pipe[0])
  );

  // Horner steps
  for (genvar s = 1; s <= qhe_pkg::NSTEP; s++) begin : g_step
    qhe_step #(
      .STEP (s)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[s]),
      .valid_i (vld[s-1]),
      .pipe_i  (pipe[s-1]),
      .valid_o (vld[s]),
      .pipe_o  (pipe[s])
    );
  end

  qhe_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en[NST-1]),
    .valid_i        (vld[NST-2]),
    .pipe_i         (pipe[qhe_pkg::NSTEP]),
    .valid_o        (vld[NST-1]),
    .position_o     (position_o),
    .first_deriv_o  (first_deriv_o),
    .second_deriv_o (second_deriv_o)
  );

  assign out_valid_o = vld[NST-1];

  // A ready sink never backs up into the input
  `QHE_ASSERT_IMPL(a_no_block, out_ready_i, in_ready_o, "input stalled with ready sink")
  // Clamped u never exceeds one in the pipeline
  `QHE_ASSERT_IMPL(a_u_clamp, vld[0], pipe[0].u <= qhe_pkg::U_ONE, "u above one after clamp")
  // With a steadily ready sink an accepted item is valid at the output in time
  `QHE_ASSERT_NEXT(a_lat, (in_xfer && out_ready_i) ##1 out_ready_i [*6], out_valid_o, "no result")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for quintic_hermite_evaluator: random and directed segments are
// checked against a cycle-free quintic Hermite evaluator kept in this file.
// Depends on qhe_pkg and the evaluator RTL.
module tb_top;

  typedef qhe_pkg::in_t in_t;
  localparam int U_W    = qhe_pkg::U_W;
  localparam int U_FRAC = qhe_pkg::U_FRAC;
  localparam logic [U_W-1:0] U_ONE = qhe_pkg::U_ONE;

  localparam in_t POS_MAX = 32'sh7FFF_FFFF;
  localparam in_t NEG_MIN = 32'sh8000_0000;
  localparam in_t ONE_Q   = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam int  HOLD_CYCLES = 80;

  // One axis of one segment plus the parameter u
  typedef struct {
    in_t            p0, v0, a0, p1, v1, a1;
    logic [U_W-1:0] u;
  } segment_t;

  // q, q' and q'' at u
  typedef struct {
    in_t pos, vel, accel;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  start_pos_i = '0;
  in_t  start_vel_i = '0;
  in_t  start_acc_i = '0;
  in_t  end_pos_i = '0;
  in_t  end_vel_i = '0;
  in_t  end_acc_i = '0;
  logic [U_W-1:0] param_u_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  in_t  position_o;
  in_t  first_deriv_o;
  in_t  second_deriv_o;

  segment_t pending_segments[$];
  sample_t  expected_samples[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  mismatches = 0;
  logic in_taken = 1'b0;

  quintic_hermite_evaluator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_pos_i    (start_pos_i),
    .start_vel_i    (start_vel_i),
    .start_acc_i    (start_acc_i),
    .end_pos_i      (end_pos_i),
    .end_vel_i      (end_vel_i),
    .end_acc_i      (end_acc_i),
    .param_u_i      (param_u_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_o     (position_o),
    .first_deriv_o  (first_deriv_o),
    .second_deriv_o (second_deriv_o)
  );

  always #5 clk_i = ~clk_i;

  // round(a * u / 2^16), ties go up; arithmetic shift is a floor
  function automatic longint scale_u(input longint a, input longint u);
    return (a * u + (longint'(1) <<< (U_FRAC - 1))) >>> U_FRAC;
  endfunction

  // Halve a doubled sum with rounding half up, clamp to 32 bits
  function automatic in_t halve_sat(input longint d);
    longint r;
    r = (d + 1) >>> 1;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return in_t'(r);
  endfunction

  // Doubled monomial coefficients, then Horner on each of the three lanes
  function automatic sample_t eval_hermite(input segment_t s);
    longint p0, v0, a0, p1, v1, a1, u;
    longint c0, c1, c2, c3, c4, c5, acc;
    sample_t r;
    p0 = longint'(s.p0);
    v0 = longint'(s.v0);
    a0 = longint'(s.a0);
    p1 = longint'(s.p1);
    v1 = longint'(s.v1);
    a1 = longint'(s.a1);
    u  = (s.u > U_ONE) ? longint'(U_ONE) : longint'(s.u);
    c0 = 2 * p0;
    c1 = 2 * v0;
    c2 = a0;
    c3 = -20 * p0 - 12 * v0 - 3 * a0 + 20 * p1 - 8 * v1 + a1;
    c4 = 30 * p0 + 16 * v0 + 3 * a0 - 30 * p1 + 14 * v1 - 2 * a1;
    c5 = -12 * p0 - 6 * v0 - a0 + 12 * p1 - 6 * v1 + a1;
    acc = c5;
    acc = scale_u(acc, u) + c4;
    acc = scale_u(acc, u) + c3;
    acc = scale_u(acc, u) + c2;
    acc = scale_u(acc, u) + c1;
    acc = scale_u(acc, u) + c0;
    r.pos = halve_sat(acc);
    acc = 5 * c5;
    acc = scale_u(acc, u) + 4 * c4;
    acc = scale_u(acc, u) + 3 * c3;
    acc = scale_u(acc, u) + 2 * c2;
    acc = scale_u(acc, u) + c1;
    r.vel = halve_sat(acc);
    acc = 20 * c5;
    acc = scale_u(acc, u) + 12 * c4;
    acc = scale_u(acc, u) + 6 * c3;
    acc = scale_u(acc, u) + 2 * c2;
    r.accel = halve_sat(acc);
    return r;
  endfunction

  task automatic add_seg(input in_t p0, input in_t v0, input in_t a0, input in_t p1,
                         input in_t v1, input in_t a1, input logic [U_W-1:0] u);
    segment_t s;
    s.p0 = p0; s.v0 = v0; s.a0 = a0;
    s.p1 = p1; s.v1 = v1; s.a1 = a1;
    s.u  = u;
    pending_segments.insert(pending_segments.size(), s);
  endtask

  // Mix of full-range, trajectory-sized and boundary values
  function automatic in_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return in_t'($urandom);
      3:       return in_t'(int'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      8: begin
        case ($urandom_range(0, 4))
          0:       return POS_MAX;
          1:       return NEG_MIN;
          2:       return '0;
          3:       return -in_t'(1);
          default: return in_t'(1);
        endcase
      end
      default: return in_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [U_W-1:0] rand_u();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return U_ONE;
      2:       return U_W'($urandom_range(0, 2 ** U_W - 1));
      default: return U_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic add_random_segs(input int n);
    for (int i = 0; i < n; i++) begin
      add_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_u());
    end
  endtask

  task automatic drain_pending();
    while (pending_segments.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input in_t exp_v, input in_t act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Sender: a new segment may go out once the previous one transferred
  always @(negedge clk_i) begin : drive_seg
    segment_t s;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_segments.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s = pending_segments.pop_front();
        start_pos_i <= s.p0;
        start_vel_i <= s.v0;
        start_acc_i <= s.a0;
        end_pos_i   <= s.p1;
        end_vel_i   <= s.v1;
        end_acc_i   <= s.a1;
        param_u_i   <= s.u;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check each result transfer, predict each input transfer
  always @(posedge clk_i) begin : score
    segment_t s;
    sample_t  want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, got %0d %0d %0d",
                   $time, position_o, first_deriv_o, second_deriv_o);
        end else begin
          want = expected_samples.pop_front();
          check_field("position", want.pos, position_o);
          check_field("first_deriv", want.vel, first_deriv_o);
          check_field("second_deriv", want.accel, second_deriv_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        s.p0 = start_pos_i; s.v0 = start_vel_i; s.a0 = start_acc_i;
        s.p1 = end_pos_i;   s.v1 = end_vel_i;   s.a1 = end_acc_i;
        s.u  = param_u_i;
        expected_samples.insert(expected_samples.size(), eval_hermite(s));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zeros, field extremes, u endpoints, u above one, saturation
    add_seg('0, '0, '0, '0, '0, '0, '0);
    add_seg('0, '0, '0, ONE_Q, '0, '0, U_ONE);
    add_seg('0, '0, '0, 10 * ONE_Q, '0, '0, 17'd32768);
    add_seg(ONE_Q, 2 * ONE_Q, -ONE_Q, 5 * ONE_Q, -ONE_Q, ONE_Q, 17'd16384);
    add_seg(ONE_Q, 2 * ONE_Q, -ONE_Q, 5 * ONE_Q, -ONE_Q, ONE_Q, 17'd65535);
    add_seg(ONE_Q, 2 * ONE_Q, -ONE_Q, 5 * ONE_Q, -ONE_Q, ONE_Q, 17'd65537);
    add_seg(ONE_Q, 2 * ONE_Q, -ONE_Q, 5 * ONE_Q, -ONE_Q, ONE_Q, 17'h1FFFF);
    add_seg(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 17'd32768);
    add_seg(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, 17'd32768);
    add_seg(POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, 17'd40000);
    add_seg(NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN, POS_MAX, 17'd40000);
    add_seg(NEG_MIN, '0, '0, POS_MAX, '0, '0, 17'd32768);
    add_seg(POS_MAX, '0, '0, NEG_MIN, '0, '0, 17'd1);
    add_seg('0, POS_MAX, '0, '0, '0, '0, 17'd32768);
    add_seg('0, '0, NEG_MIN, '0, '0, '0, 17'd32768);
    add_seg('0, '0, '0, '0, NEG_MIN, '0, 17'd32768);
    add_seg('0, '0, '0, '0, '0, POS_MAX, 17'd32768);
    // odd low bits exercise the rounding ties
    add_seg(in_t'(1), -in_t'(1), in_t'(1), -in_t'(1), in_t'(3), -in_t'(3), 17'd32768);
    add_seg(-in_t'(1), in_t'(1), -in_t'(1), '0, '0, in_t'(1), 17'd1);
    add_seg(-in_t'(1), -in_t'(1), -in_t'(1), -in_t'(1), -in_t'(1), -in_t'(1), U_ONE);
    add_seg(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, '0);
    add_seg(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN, 17'h10000);
    add_random_segs(140);
    drain_pending();

    // Sender idles most cycles
    send_idle_pct = 66;
    add_random_segs(140);
    drain_pending();

    // Receiver stalls most cycles
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    add_random_segs(140);
    drain_pending();

    // Occasional idling on both sides
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    add_random_segs(140);
    drain_pending();

    // Long receiver hold-off while the sender keeps offering: pipeline fills
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    add_random_segs(120);
    drain_pending();

    while (expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
